@@ rtl/mlq_pkg.sv @@
// shared types and constants of the multilevel queue scheduler
// controller state encoding, command and status bundles, fixed field widths
// no dependencies
`default_nettype none

package mlq_pkg;

	localparam int TIME_W    = 16;
	localparam int OUT_W     = 22;
	localparam int IDX_OUT_W = 6;

	localparam logic [TIME_W-1:0] DEF_QUANTUM = 16'd4;

	localparam logic CLASS_USER = 1'b0;
	localparam logic CLASS_SYS  = 1'b1;

	typedef enum logic [3:0] {
		S_LOAD,
		S_START,
		S_PASS,
		S_U_RD,
		S_U_EV,
		S_U_END,
		S_S_RD,
		S_S_EV,
		S_JUMP,
		S_CHECK,
		S_O_RD,
		S_O_LD,
		S_O_HOLD
	} state_t;

	typedef struct packed {
		logic load;
		logic batch_clr;
		logic scan_clr;
		logic pass_clr;
		logic rd;
		logic idx_inc;
		logic eval_user;
		logic eval_sys;
		logic jump;
		logic out_load;
		logic batch_end;
	} cmd_t;

	typedef struct packed {
		logic idx_last;
		logic ran;
		logic sys_hit;
		logic all_done;
	} sts_t;

endpackage

`default_nettype wire

@@ rtl/mlq_ctrl.sv @@
// controller state machine of the multilevel queue scheduler
// sequences loading, user and system scans, idle jumps and result output
// depends on mlq_pkg
`default_nettype none

module mlq_ctrl import mlq_pkg::*; (
	input  logic clk,
	input  logic arst_n,
	input  logic in_valid,
	input  logic last_process,
	input  logic out_ready,
	input  sts_t sts,
	output logic in_ready,
	output logic out_valid,
	output cmd_t cmd
);

	state_t state_q, state_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_LOAD;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d = state_q;
		case (state_q)
			S_LOAD: begin
				if (in_valid && last_process) state_d = S_START;
			end
			S_START:  state_d = S_PASS;
			S_PASS:   state_d = S_U_RD;
			S_U_RD:   state_d = S_U_EV;
			S_U_EV:   state_d = sts.idx_last ? S_U_END : S_U_RD;
			S_U_END:  state_d = sts.ran ? S_CHECK : S_S_RD;
			S_S_RD:   state_d = S_S_EV;
			S_S_EV: begin
				if (sts.sys_hit) state_d = S_CHECK;
				else if (sts.idx_last) state_d = S_JUMP;
				else state_d = S_S_RD;
			end
			S_JUMP:   state_d = S_CHECK;
			S_CHECK:  state_d = sts.all_done ? S_O_RD : S_PASS;
			S_O_RD:   state_d = S_O_LD;
			S_O_LD:   state_d = S_O_HOLD;
			S_O_HOLD: begin
				if (out_ready) state_d = sts.idx_last ? S_LOAD : S_O_RD;
			end
			default:  state_d = S_LOAD;
		endcase
	end

	always_comb begin
		cmd       = '0;
		in_ready  = 1'b0;
		out_valid = 1'b0;
		case (state_q)
			S_LOAD: begin
				in_ready = 1'b1;
				cmd.load = in_valid;
			end
			S_START: cmd.batch_clr = 1'b1;
			S_PASS: begin
				cmd.scan_clr = 1'b1;
				cmd.pass_clr = 1'b1;
			end
			S_U_RD: cmd.rd = 1'b1;
			S_U_EV: begin
				cmd.eval_user = 1'b1;
				cmd.idx_inc   = 1'b1;
			end
			S_U_END: cmd.scan_clr = 1'b1;
			S_S_RD:  cmd.rd = 1'b1;
			S_S_EV: begin
				cmd.eval_sys = 1'b1;
				cmd.idx_inc  = 1'b1;
			end
			S_JUMP:  cmd.jump = 1'b1;
			S_CHECK: cmd.scan_clr = 1'b1;
			S_O_RD:  cmd.rd = 1'b1;
			S_O_LD:  cmd.out_load = 1'b1;
			S_O_HOLD: begin
				out_valid     = 1'b1;
				cmd.idx_inc   = out_ready;
				cmd.batch_end = out_ready && sts.idx_last;
			end
			default: cmd = '0;
		endcase
	end

endmodule

`default_nettype wire

@@ rtl/mlq_dp.sv @@
// datapath of the multilevel queue scheduler
// descriptor memory, simulated clock, slice arithmetic and result registers
// depends on mlq_pkg
`default_nettype none

module mlq_dp import mlq_pkg::*; #(
	parameter int MAX_PROCS = 32
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  cmd_t                  cmd,
	output sts_t                  sts,
	input  logic                  cfg_we,
	input  logic [TIME_W-1:0]     cfg_data,
	input  logic [TIME_W-1:0]     arrival_time,
	input  logic [TIME_W-1:0]     burst_time,
	input  logic                  queue_class,
	output logic [IDX_OUT_W-1:0]  process_index,
	output logic [OUT_W-1:0]      completion_time,
	output logic [OUT_W-1:0]      turnaround_time,
	output logic [OUT_W-1:0]      waiting_time,
	output logic [OUT_W-1:0]      response_time,
	output logic                  last_result
);

	localparam int IDX_W    = (MAX_PROCS > 1) ? $clog2(MAX_PROCS) : 1;
	localparam int CNT_W    = $clog2(MAX_PROCS + 1);
	localparam int CLK_CALC = $clog2((MAX_PROCS + 1) * (2 ** TIME_W));
	localparam int CLK_W    = (CLK_CALC > OUT_W) ? CLK_CALC : OUT_W;
	localparam logic [CNT_W-1:0] CNT_MAX = CNT_W'(MAX_PROCS);

	typedef struct packed {
		logic [TIME_W-1:0] arrival;
		logic [TIME_W-1:0] burst;
		logic [TIME_W-1:0] remaining;
		logic              cls;
		logic              started;
		logic [CLK_W-1:0]  response;
		logic [CLK_W-1:0]  completion;
	} entry_t;

	entry_t             mem_q [MAX_PROCS];
	entry_t             rdata_q;
	entry_t             wdata;
	logic               we;
	logic [IDX_W-1:0]   waddr;

	logic [IDX_W-1:0]   idx_q;
	logic [CNT_W-1:0]   count_q;
	logic [CNT_W-1:0]   finished_q;
	logic [CLK_W-1:0]   clock_q;
	logic [TIME_W-1:0]  min_arr_q;
	logic [TIME_W-1:0]  quantum_q;
	logic               ran_q;

	logic [TIME_W-1:0]  burst_fix;
	logic [TIME_W-1:0]  q_eff;
	logic [TIME_W-1:0]  slice_len;
	logic [TIME_W-1:0]  adv;
	logic [CLK_W-1:0]   clock_n;
	logic [CLK_W-1:0]   tat_calc;
	logic [CLK_W-1:0]   wait_calc;
	logic               arrived;
	logic               pending;
	logic               user_hit;
	logic               sys_hit;
	logic               run;
	logic               done;
	logic               load_ok;
	logic               idx_last;

	logic [IDX_OUT_W-1:0] index_q;
	logic [OUT_W-1:0]     completion_q;
	logic [OUT_W-1:0]     turnaround_q;
	logic [OUT_W-1:0]     waiting_q;
	logic [OUT_W-1:0]     response_q;
	logic                 last_q;

	assign burst_fix = (burst_time == '0) ? TIME_W'(1) : burst_time;
	assign q_eff     = (quantum_q == '0) ? TIME_W'(1) : quantum_q;
	assign load_ok   = cmd.load && (count_q < CNT_MAX);

	assign arrived   = CLK_W'(rdata_q.arrival) <= clock_q;
	assign pending   = rdata_q.remaining != '0;
	assign user_hit  = (rdata_q.cls == CLASS_USER) && arrived && pending;
	assign sys_hit   = (rdata_q.cls == CLASS_SYS) && arrived && pending;
	assign run       = (cmd.eval_user && user_hit) || (cmd.eval_sys && sys_hit);
	assign slice_len = (rdata_q.cls == CLASS_SYS) ? rdata_q.remaining : q_eff;
	assign done      = rdata_q.remaining <= slice_len;
	assign adv       = done ? rdata_q.remaining : slice_len;
	assign clock_n   = clock_q + CLK_W'(adv);
	assign idx_last  = (CNT_W'(idx_q) + 1'b1) == count_q;

	assign tat_calc  = rdata_q.completion - CLK_W'(rdata_q.arrival);
	assign wait_calc = tat_calc - CLK_W'(rdata_q.burst);

	always_comb begin
		we    = 1'b0;
		waddr = idx_q;
		wdata = rdata_q;
		if (load_ok) begin
			we               = 1'b1;
			waddr            = count_q[IDX_W-1:0];
			wdata.arrival    = arrival_time;
			wdata.burst      = burst_fix;
			wdata.remaining  = burst_fix;
			wdata.cls        = queue_class;
			wdata.started    = 1'b0;
			wdata.response   = '0;
			wdata.completion = '0;
		end else if (run) begin
			we            = 1'b1;
			wdata.started = 1'b1;
			if (!rdata_q.started) wdata.response = clock_q - CLK_W'(rdata_q.arrival);
			wdata.remaining = done ? '0 : rdata_q.remaining - slice_len;
			if (done) wdata.completion = clock_n;
		end
	end

	// descriptor memory, registered read
	always_ff @(posedge clk) begin
		if (we) mem_q[waddr] <= wdata;
		if (cmd.rd) rdata_q <= mem_q[idx_q];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q    <= '0;
			finished_q <= '0;
			clock_q    <= '0;
			idx_q      <= '0;
			ran_q      <= 1'b0;
			min_arr_q  <= '1;
			quantum_q  <= DEF_QUANTUM;
		end else begin
			if (cfg_we) quantum_q <= cfg_data;
			if (cmd.batch_end) count_q <= '0;
			else if (load_ok) count_q <= count_q + 1'b1;
			if (cmd.scan_clr) idx_q <= '0;
			else if (cmd.idx_inc) idx_q <= idx_q + 1'b1;
			if (cmd.pass_clr) begin
				ran_q     <= 1'b0;
				min_arr_q <= '1;
			end
			// earliest arrival of any unfinished process, for idle stretches
			if (cmd.eval_user) begin
				if (user_hit) ran_q <= 1'b1;
				if (pending && (rdata_q.arrival < min_arr_q)) min_arr_q <= rdata_q.arrival;
			end
			if (cmd.batch_clr) begin
				clock_q    <= '0;
				finished_q <= '0;
			end else if (run) begin
				clock_q <= clock_n;
				if (done) finished_q <= finished_q + 1'b1;
			end else if (cmd.jump) begin
				clock_q <= CLK_W'(min_arr_q);
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.out_load) begin
			index_q      <= IDX_OUT_W'(idx_q);
			completion_q <= rdata_q.completion[OUT_W-1:0];
			turnaround_q <= tat_calc[OUT_W-1:0];
			waiting_q    <= wait_calc[OUT_W-1:0];
			response_q   <= rdata_q.response[OUT_W-1:0];
			last_q       <= idx_last;
		end
	end

	assign sts.idx_last = idx_last;
	assign sts.ran      = ran_q;
	assign sts.sys_hit  = sys_hit;
	assign sts.all_done = finished_q == count_q;

	assign process_index   = index_q;
	assign completion_time = completion_q;
	assign turnaround_time = turnaround_q;
	assign waiting_time    = waiting_q;
	assign response_time   = response_q;
	assign last_result     = last_q;

endmodule

`default_nettype wire

@@ rtl/multilevel_queue_scheduler.sv @@
// multilevel queue scheduler top level: controller and datapath, depends on mlq_pkg
// flow: descriptors load one per cycle; after the last one each pass runs a user scan over
// every loaded descriptor and, if no user process ran, a system scan up to the first ready
// system process, both paced by the single read port of the descriptor memory; an idle
// stretch is skipped by a jump state; each result is then read, loaded and held until out_ready
// reset: control state and counters cleared, quantum 4, memory contents left as they are
`default_nettype none

module multilevel_queue_scheduler import mlq_pkg::*; #(
	parameter int MAX_PROCS = 32
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 cfg_valid,
	output logic                 cfg_ready,
	input  logic [TIME_W-1:0]    cfg_data,
	input  logic                 in_valid,
	output logic                 in_ready,
	input  logic [TIME_W-1:0]    arrival_time,
	input  logic [TIME_W-1:0]    burst_time,
	input  logic                 queue_class,
	input  logic                 last_process,
	output logic                 out_valid,
	input  logic                 out_ready,
	output logic [IDX_OUT_W-1:0] process_index,
	output logic [OUT_W-1:0]     completion_time,
	output logic [OUT_W-1:0]     turnaround_time,
	output logic [OUT_W-1:0]     waiting_time,
	output logic [OUT_W-1:0]     response_time,
	output logic                 last_result
);

	cmd_t cmd;
	sts_t sts;

	assign cfg_ready = 1'b1;

	mlq_ctrl u_ctrl (
		.clk          (clk),
		.arst_n       (arst_n),
		.in_valid     (in_valid),
		.last_process (last_process),
		.out_ready    (out_ready),
		.sts          (sts),
		.in_ready     (in_ready),
		.out_valid    (out_valid),
		.cmd          (cmd)
	);

	mlq_dp #(
		.MAX_PROCS (MAX_PROCS)
	) u_dp (
		.clk             (clk),
		.arst_n          (arst_n),
		.cmd             (cmd),
		.sts             (sts),
		.cfg_we          (cfg_valid && cfg_ready),
		.cfg_data        (cfg_data),
		.arrival_time    (arrival_time),
		.burst_time      (burst_time),
		.queue_class     (queue_class),
		.process_index   (process_index),
		.completion_time (completion_time),
		.turnaround_time (turnaround_time),
		.waiting_time    (waiting_time),
		.response_time   (response_time),
		.last_result     (last_result)
	);

endmodule

`default_nettype wire

@@ rtl/mlq_checker.sv @@
// port level checks of the multilevel queue scheduler and their bind
// sees only the top level ports, depends on mlq_pkg for field widths
`default_nettype none

module mlq_checker import mlq_pkg::*; (
	input logic                 clk,
	input logic                 arst_n,
	input logic                 in_valid,
	input logic                 in_ready,
	input logic                 last_process,
	input logic                 out_valid,
	input logic                 out_ready,
	input logic [IDX_OUT_W-1:0] process_index,
	input logic [OUT_W-1:0]     completion_time,
	input logic                 last_result
);

	a_load_xor_emit: assert property (@(posedge clk) disable iff (!arst_n)
		!(in_ready && out_valid))
		else $error("loading and emitting at once");

	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(process_index)
			&& $stable(completion_time))
		else $error("stalled result changed");

	a_more_results: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_ready && !last_result |=> !in_ready)
		else $error("loading before the batch is fully emitted");

	a_batch_done: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_ready && last_result |=> in_ready)
		else $error("not ready for a new batch after the final result");

	a_keep_loading: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && in_ready && !last_process |=> in_ready)
		else $error("left loading without a final descriptor");

endmodule

bind multilevel_queue_scheduler mlq_checker u_mlq_checker (
	.clk             (clk),
	.arst_n          (arst_n),
	.in_valid        (in_valid),
	.in_ready        (in_ready),
	.last_process    (last_process),
	.out_valid       (out_valid),
	.out_ready       (out_ready),
	.process_index   (process_index),
	.completion_time (completion_time),
	.last_result     (last_result)
);

`default_nettype wire
